@@ rtl/pid_pkg.sv @@
package pid_pkg;

    localparam int COORD_BITS = 24;
    localparam int PID_BITS   = 16;
    localparam int PPU_BITS   = 16;
    localparam int OP_BITS    = 2;
    localparam int DVD_BITS   = COORD_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DVD_BITS);
    localparam int IN_BITS    = OP_BITS + 3 * COORD_BITS + PID_BITS + PPU_BITS;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 7 * COORD_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_BITS-1:0] OP_BSIZE   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_BCOUNT  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_STRIDE  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_BSTRIDE = 2'd3;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        t_coord              pmin;
        t_coord              plen;
        logic [PID_BITS-1:0] pid;
        t_coord              size;
        logic [PPU_BITS-1:0] ppu;
        logic                reord;
    } t_item;

    typedef struct packed {
        t_coord seq_begin;
        t_coord seq_length;
        t_coord seq_period;
        t_coord seq_count;
        t_coord sub_min;
        t_coord sub_length;
        t_coord parts_total;
        logic   reorders;
        logic   invalid;
        logic   last;
    } t_result;

    typedef struct packed {
        logic                start;
        logic [DVD_BITS-1:0] dividend;
        t_coord              divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DVD_BITS-1:0] quot;
        t_coord              rem;
    } t_div_rsp;

endpackage

@@ rtl/pid_front.sv @@
module pid_front
    import pid_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [IN_TDATA_BITS-1:0] i_data,
    output logic                     o_item_valid,
    output t_item                    o_item,
    input  logic                     i_pop
);

    t_item      w_item;
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_coord     w_size;
    logic [PPU_BITS-1:0] w_ppu;

    always_comb begin
        w_size = i_data[OP_BITS+3*COORD_BITS+PID_BITS-1 -: COORD_BITS];
        w_ppu  = i_data[IN_BITS-1 -: PPU_BITS];
        w_item.op    = i_data[OP_BITS-1:0];
        w_item.pmin  = i_data[OP_BITS+COORD_BITS-1 -: COORD_BITS];
        w_item.plen  = i_data[OP_BITS+2*COORD_BITS-1 -: COORD_BITS];
        w_item.pid   = i_data[OP_BITS+2*COORD_BITS+PID_BITS-1 -: PID_BITS];
        w_item.size  = (w_size == '0) ? t_coord'(1) : w_size;
        w_item.ppu   = (w_ppu == '0) ? PPU_BITS'(1) : w_ppu;
        w_item.reord = (w_item.op == OP_STRIDE) || (w_item.op == OP_BSTRIDE);
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign w_pop        = i_pop && o_item_valid;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_item;
    end

endmodule

@@ rtl/pid_div.sv @@
module pid_div
    import pid_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DVD_BITS-1:0]     r_rem;
    logic [DVD_BITS-1:0]     r_quo;
    t_coord                  r_div;
    logic [DVD_BITS-1:0]     w_rs;
    logic [DVD_BITS-1:0]     w_dz;
    logic                    w_ge;

    always_comb begin
        w_rs = {r_rem[DVD_BITS-2:0], r_quo[DVD_BITS-1]};
        w_dz = {1'b0, r_div};
        w_ge = (w_rs >= w_dz);
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DVD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rs - w_dz) : w_rs;
            r_quo <= {r_quo[DVD_BITS-2:0], w_ge};
        end
    end

endmodule

@@ rtl/pid_back.sv @@
module pid_back
    import pid_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_item_valid,
    input  t_item    i_item,
    output logic     o_pop,
    output t_div_req o_div_req,
    input  t_div_rsp i_div_rsp,
    output logic     o_res_valid,
    output t_result  o_res,
    input  logic     i_res_ready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRE  = 4'd1;
    localparam logic [3:0] S_W1   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_SL   = 4'd5;
    localparam logic [3:0] S_W2   = 4'd6;
    localparam logic [3:0] S_W3   = 4'd7;
    localparam logic [3:0] S_W4   = 4'd8;
    localparam logic [3:0] S_M2   = 4'd9;
    localparam logic [3:0] S_E0   = 4'd10;
    localparam logic [3:0] S_E1   = 4'd11;
    localparam logic [3:0] S_E2   = 4'd12;
    localparam logic [3:0] S_E3   = 4'd13;
    localparam logic [3:0] S_E4   = 4'd14;
    localparam logic [3:0] S_EI   = 4'd15;

    logic [3:0] r_state, n_state;
    logic [3:0] r_after, n_after;
    t_item      r_it, n_it;
    t_coord     r_parts, n_parts;
    t_coord     r_q, n_q;
    t_coord     r_r, n_r;
    t_coord     r_full, n_full;
    t_coord     r_partial, n_partial;
    t_coord     r_xb, n_xb;
    t_coord     r_spill, n_spill;
    t_coord     r_sl, n_sl;
    t_coord     r_fs, n_fs;
    t_coord     r_mine, n_mine;
    t_coord     r_ma, n_ma;
    t_coord     r_mb, n_mb;
    logic [2*COORD_BITS-1:0] r_mul, n_mul;
    t_result    r_out, n_out;
    logic       r_ovalid;
    logic       w_emit;
    logic       w_free;
    t_coord     w_pid;
    t_coord     w_ppu;
    t_coord     w_mlo;
    t_coord     w_tmp;
    t_coord     w_q;
    logic       w_spl;

    assign w_free      = !r_ovalid || i_res_ready;
    assign w_pid       = {{(COORD_BITS-PID_BITS){1'b0}}, r_it.pid};
    assign w_ppu       = {{(COORD_BITS-PPU_BITS){1'b0}}, r_it.ppu};
    assign w_mlo       = r_mul[COORD_BITS-1:0];
    assign w_q         = i_div_rsp.quot[COORD_BITS-1:0];
    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_it      = r_it;
        n_parts   = r_parts;
        n_q       = r_q;
        n_r       = r_r;
        n_full    = r_full;
        n_partial = r_partial;
        n_xb      = r_xb;
        n_spill   = r_spill;
        n_sl      = r_sl;
        n_fs      = r_fs;
        n_mine    = r_mine;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_mul     = r_mul;
        n_out     = r_out;
        w_emit    = 1'b0;
        w_tmp     = '0;
        w_spl     = 1'b0;
        o_pop     = 1'b0;
        o_div_req = '0;

        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_it    = i_item;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                case (r_it.op)
                    OP_BSIZE: begin
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = {1'b0, r_it.plen} + {1'b0, r_it.size}
                                             - DVD_BITS'(1);
                        o_div_req.divisor  = r_it.size;
                        n_state            = S_W1;
                    end
                    OP_BSTRIDE: begin
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = {1'b0, r_it.plen};
                        o_div_req.divisor  = r_it.size;
                        n_state            = S_W1;
                    end
                    OP_BCOUNT: begin
                        w_tmp   = (r_it.size < r_it.plen) ? r_it.size : r_it.plen;
                        n_parts = (w_tmp == '0) ? t_coord'(1) : w_tmp;
                        n_state = S_CHK;
                    end
                    default: begin
                        w_tmp   = (w_ppu < r_it.plen) ? w_ppu : r_it.plen;
                        n_parts = (w_tmp == '0) ? t_coord'(1) : w_tmp;
                        n_state = S_CHK;
                    end
                endcase
            end
            S_W1: begin
                if (i_div_rsp.done) begin
                    if (r_it.op == OP_BSIZE) w_tmp = w_q;
                    else                     w_tmp = (w_q < w_ppu) ? w_q : w_ppu;
                    n_parts = (w_tmp == '0) ? t_coord'(1) : w_tmp;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (w_pid >= r_parts) begin
                    n_state = S_EI;
                end else begin
                    case (r_it.op)
                        OP_BSIZE: begin
                            n_ma    = w_pid;
                            n_mb    = r_it.size;
                            n_after = S_E0;
                            n_state = S_MUL;
                        end
                        OP_BSTRIDE: begin
                            n_ma    = r_it.size;
                            n_mb    = r_parts;
                            n_after = S_SL;
                            n_state = S_MUL;
                        end
                        default: begin
                            o_div_req.start    = 1'b1;
                            o_div_req.dividend = {1'b0, r_it.plen};
                            o_div_req.divisor  = r_parts;
                            n_state            = S_W2;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_mul   = r_ma * r_mb;
                n_state = r_after;
            end
            S_SL: begin
                n_sl               = w_mlo;
                o_div_req.start    = 1'b1;
                o_div_req.dividend = {1'b0, r_it.plen};
                o_div_req.divisor  = w_mlo;
                n_state            = S_W3;
            end
            S_W2: begin
                if (i_div_rsp.done) begin
                    n_q = w_q;
                    n_r = i_div_rsp.rem;
                    if (r_it.op == OP_BCOUNT) begin
                        n_ma    = w_q;
                        n_mb    = w_pid;
                        n_after = S_E1;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_E2;
                    end
                end
            end
            S_W3: begin
                if (i_div_rsp.done) begin
                    n_full             = w_q;
                    n_partial          = i_div_rsp.rem;
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = {1'b0, i_div_rsp.rem};
                    o_div_req.divisor  = r_it.size;
                    n_state            = S_W4;
                end
            end
            S_W4: begin
                if (i_div_rsp.done) begin
                    n_xb    = w_q;
                    n_spill = i_div_rsp.rem;
                    n_ma    = r_full;
                    n_mb    = r_it.size;
                    n_after = S_M2;
                    n_state = S_MUL;
                end
            end
            S_M2: begin
                n_fs    = w_mlo;
                n_ma    = w_pid;
                n_mb    = r_it.size;
                n_after = S_E3;
                n_state = S_MUL;
            end
            S_E0: begin
                w_tmp = r_it.plen - w_mlo;
                if (r_it.size < w_tmp) w_tmp = r_it.size;
                n_out = '{r_it.pmin + w_mlo, w_tmp, w_tmp, t_coord'(1),
                          r_it.pmin + w_mlo, w_tmp, r_parts, 1'b0, 1'b0, 1'b1};
                w_emit = 1'b1;
            end
            S_E1: begin
                w_tmp = ((w_pid + t_coord'(1)) < r_parts) ? r_q : (r_it.plen - w_mlo);
                n_out = '{r_it.pmin + w_mlo, w_tmp, w_tmp, t_coord'(1),
                          r_it.pmin + w_mlo, w_tmp, r_parts, 1'b0, 1'b0, 1'b1};
                w_emit = 1'b1;
            end
            S_E2: begin
                w_tmp = r_q + t_coord'(r_r > w_pid);
                n_out = '{r_it.pmin + w_pid, t_coord'(1), r_parts, w_tmp,
                          t_coord'(0), w_tmp, r_parts, 1'b1, 1'b0, 1'b1};
                w_emit = 1'b1;
            end
            S_E3: begin
                if (r_xb > w_pid)       w_tmp = r_fs + r_it.size;
                else if (r_xb == w_pid) w_tmp = r_fs + r_spill;
                else                    w_tmp = r_fs;
                w_spl  = (r_xb == w_pid) && (r_spill != '0);
                n_mine = w_tmp;
                n_out  = '{r_it.pmin + w_mlo, r_it.size, r_sl,
                           r_full + t_coord'(r_xb > w_pid), t_coord'(0), w_tmp,
                           r_parts, 1'b1, 1'b0, !w_spl};
                w_emit = 1'b1;
            end
            S_E4: begin
                n_out = '{r_it.pmin + r_it.plen - r_spill, r_spill, r_spill,
                          t_coord'(1), t_coord'(0), r_mine, r_parts, 1'b1, 1'b0, 1'b1};
                w_emit = 1'b1;
            end
            S_EI: begin
                n_out = '{t_coord'(0), t_coord'(0), t_coord'(0), t_coord'(0),
                          t_coord'(0), t_coord'(0), r_parts, r_it.reord, 1'b1, 1'b1};
                w_emit = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_emit) begin
            if (w_free) begin
                n_state = n_out.last ? S_IDLE : S_E4;
            end else begin
                n_out  = r_out;
                n_mine = r_mine;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit && w_free) r_ovalid <= 1'b1;
            else if (i_res_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_after   <= n_after;
        r_it      <= n_it;
        r_parts   <= n_parts;
        r_q       <= n_q;
        r_r       <= n_r;
        r_full    <= n_full;
        r_partial <= n_partial;
        r_xb      <= n_xb;
        r_spill   <= n_spill;
        r_sl      <= n_sl;
        r_fs      <= n_fs;
        r_mine    <= n_mine;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_mul     <= n_mul;
        r_out     <= n_out;
    end

endmodule

@@ rtl/partition_interval_descriptor_unit.sv @@
// Channel   Dir  Handshake                     Payload
// query     in   i_s_axis_tvalid/o_s_axis_tready  tdata: op, min, length, part, size, ppu
// result    out  o_m_axis_tvalid/i_m_axis_tready  tdata, tuser, tlast
//
// For a valid part, a query uses the shared one-bit-per-cycle divider once in block size,
// block count and stride modes, and three times in block stride mode.
// A two-entry queue takes new queries while the back end works or a result waits.
// Synchronous active-low reset clears control state only.
// A stalled result holds in the output register; the back end waits on it.
module partition_interval_descriptor_unit
    import pid_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // operation, parent_min, parent_length, part_id, size_arg, ppu_count
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // seq_begin, seq_length, seq_period, seq_count, sub_min, sub_length, parts_total
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    // reorders, invalid
    output logic [1:0]                o_m_axis_tuser,
    output logic                      o_m_axis_tlast
);

    logic     w_item_valid;
    t_item    w_item;
    logic     w_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_result  w_res;

    pid_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    pid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    pid_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp),
        .o_res_valid  (o_m_axis_tvalid),
        .o_res        (w_res),
        .i_res_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = OUT_TDATA_BITS'({w_res.parts_total, w_res.sub_length,
                                             w_res.sub_min, w_res.seq_count,
                                             w_res.seq_period, w_res.seq_length,
                                             w_res.seq_begin});
    assign o_m_axis_tuser = {w_res.invalid, w_res.reorders};
    assign o_m_axis_tlast = w_res.last;

endmodule

@@ rtl/pid_checker.sv @@
module pid_checker
    import pid_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    input logic [1:0]                o_m_axis_tuser,
    input logic                      o_m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_inv_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tlast)
        else $error("invalid result not last");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata[6*COORD_BITS-1:0] == '0)
        else $error("invalid result carries data");

    a_reord_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[5*COORD_BITS-1 -: COORD_BITS] == '0)
        else $error("reordering result with nonzero sub_min");

    a_order_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] && !o_m_axis_tuser[1] |->
            o_m_axis_tdata[4*COORD_BITS-1 -: COORD_BITS] == COORD_BITS'(1)
            && o_m_axis_tlast)
        else $error("ordered result not a single interval");

endmodule

bind partition_interval_descriptor_unit pid_checker u_pid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
